// ===== rtl/sstf_pkg.sv =====
package sstf_pkg;

  localparam int MAX_REQUESTS_DEF = 16;
  localparam int CYL_BITS_DEF     = 12;

  localparam int CYL_FIELD_W   = 12;
  localparam int INDEX_FIELD_W = 4;
  localparam int SUM_W         = 16;
  localparam logic [SUM_W-1:0] SUM_MAX = 16'hFFFF;

  typedef struct packed {
    logic [CYL_FIELD_W-1:0] cylinder;
    logic                   last_request;
  } req_t;

  typedef struct packed {
    logic [INDEX_FIELD_W-1:0] served_index;
    logic [CYL_FIELD_W-1:0]   served_cylinder;
    logic [CYL_FIELD_W-1:0]   seek_distance;
    logic [SUM_W-1:0]         total_movement;
    logic                     truncated;
    logic                     last_result;
  } res_t;

  typedef struct packed {
    logic load;
    logic begin_batch;
    logic scan_rd;
    logic commit;
    logic last_service;
    logic clear_batch;
  } cmd_t;

endpackage

// ===== rtl/sstf_ram.sv =====
module sstf_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sstf_datapath.sv =====
module sstf_datapath #(
  parameter int MAX_REQUESTS = sstf_pkg::MAX_REQUESTS_DEF,
  parameter int CYL_BITS     = sstf_pkg::CYL_BITS_DEF,
  localparam int IDX_W = $clog2(MAX_REQUESTS),
  localparam int CNT_W = $clog2(MAX_REQUESTS + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sstf_pkg::cmd_t                      cmd,
  input  logic [IDX_W-1:0]                    scan_addr,
  input  sstf_pkg::req_t                      req,
  input  logic                                cfg_we,
  input  logic [sstf_pkg::CYL_FIELD_W-1:0]    cfg_wdata,
  output logic [CNT_W-1:0]                    count,
  output logic                                done,
  output sstf_pkg::res_t                      res
);

  logic [sstf_pkg::CYL_FIELD_W-1:0] start_head;
  logic [MAX_REQUESTS-1:0]          mask;
  logic                             overflow;
  logic [CYL_BITS-1:0]              head;
  logic [sstf_pkg::SUM_W-1:0]       sum;
  logic                             found;
  logic [CYL_BITS-1:0]              best_dist;
  logic [CYL_BITS-1:0]              best_cyl;
  logic [IDX_W-1:0]                 best_idx;
  logic                             rd_valid;
  logic [IDX_W-1:0]                 rd_idx;
  logic [CYL_BITS-1:0]              rdata;
  logic                             full;
  logic                             wr_en;
  logic [CYL_BITS-1:0]              head_gap;
  logic [sstf_pkg::SUM_W:0]         sum_wide;
  logic [sstf_pkg::SUM_W-1:0]       sum_next;

  assign full  = (count == CNT_W'(MAX_REQUESTS));
  assign wr_en = cmd.load && !full;

  sstf_ram #(
    .WIDTH(CYL_BITS),
    .DEPTH(MAX_REQUESTS)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(count[IDX_W-1:0]),
    .wdata(CYL_BITS'(req.cylinder)),
    .raddr(scan_addr),
    .rdata(rdata)
  );

  assign head_gap = (rdata >= head) ? (rdata - head) : (head - rdata);
  assign sum_wide = {1'b0, sum} + (sstf_pkg::SUM_W + 1)'(best_dist);
  assign sum_next = sum_wide[sstf_pkg::SUM_W] ? sstf_pkg::SUM_MAX
                                              : sum_wide[sstf_pkg::SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      start_head <= '0;
      mask       <= '0;
      count      <= '0;
      overflow   <= 1'b0;
      head       <= '0;
      sum        <= '0;
      found      <= 1'b0;
      rd_valid   <= 1'b0;
      done       <= 1'b0;
    end else begin
      if (cfg_we) begin
        start_head <= cfg_wdata;
      end
      rd_valid <= cmd.scan_rd;
      rd_idx   <= scan_addr;
      done     <= cmd.commit;

      if (cmd.load) begin
        if (full) begin
          overflow <= 1'b1;
        end else begin
          count <= count + CNT_W'(1);
        end
      end

      if (cmd.begin_batch) begin
        head  <= CYL_BITS'(start_head);
        sum   <= '0;
        found <= 1'b0;
      end

      if (rd_valid && !mask[rd_idx]) begin
        if (!found || head_gap < best_dist) begin
          found     <= 1'b1;
          best_dist <= head_gap;
          best_cyl  <= rdata;
          best_idx  <= rd_idx;
        end
      end

      if (cmd.commit) begin
        mask[best_idx]      <= 1'b1;
        head                <= best_cyl;
        sum                 <= sum_next;
        found               <= 1'b0;
        res.served_index    <= sstf_pkg::INDEX_FIELD_W'(best_idx);
        res.served_cylinder <= sstf_pkg::CYL_FIELD_W'(best_cyl);
        res.seek_distance   <= sstf_pkg::CYL_FIELD_W'(best_dist);
        res.total_movement  <= sum_next;
        res.truncated       <= overflow;
        res.last_result     <= cmd.last_service;
      end

      if (cmd.clear_batch) begin
        mask     <= '0;
        count    <= '0;
        overflow <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/sstf_ctrl.sv =====
module sstf_ctrl #(
  parameter int MAX_REQUESTS = sstf_pkg::MAX_REQUESTS_DEF,
  localparam int IDX_W = $clog2(MAX_REQUESTS),
  localparam int CNT_W = $clog2(MAX_REQUESTS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             last_request,
  input  logic [CNT_W-1:0] count,
  output logic             busy,
  output sstf_pkg::cmd_t   cmd,
  output logic [IDX_W-1:0] scan_addr
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] served;
  logic             accept;
  logic             scan_end;
  logic             final_service;
  logic [IDX_W-1:0] scan_idx_q;

  assign busy          = (state != S_IDLE);
  assign accept        = start && !busy;
  assign scan_addr     = scan_idx_q;
  assign scan_end      = (CNT_W'(scan_idx_q) + CNT_W'(1) == count);
  assign final_service = (served + CNT_W'(1) == count);

  always_comb begin
    cmd              = '0;
    cmd.load         = accept;
    cmd.begin_batch  = accept && last_request;
    cmd.scan_rd      = (state == S_SCAN);
    cmd.commit       = (state == S_COMMIT);
    cmd.last_service = (state == S_COMMIT) && final_service;
    cmd.clear_batch  = (state == S_COMMIT) && final_service;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      served     <= '0;
      scan_idx_q <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && last_request) begin
            state      <= S_SCAN;
            served     <= '0;
            scan_idx_q <= '0;
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            state <= S_DRAIN;
          end else begin
            scan_idx_q <= scan_idx_q + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          scan_idx_q <= '0;
          if (final_service) begin
            state <= S_IDLE;
          end else begin
            served <= served + CNT_W'(1);
            state  <= S_SCAN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/sstf_disk_request_scheduler_core.sv =====
// channel   | ports                      | transaction
// ----------+----------------------------+---------------------------------------
// request   | start, busy, req           | start high and busy low at clk edge
// result    | done, res                  | done high for one cycle, no stall
// config    | cfg_we, cfg_wdata          | start_head written when cfg_we high
//
// a request that is not the last is taken at the clk edge and busy stays low
// the last request starts scheduling: each service scans every stored entry
// through the single store read port, then drains the read and commits the
// selection, and the batch finishes once every stored request is served
// synchronous reset clears batch state and start_head; the store needs no clear
// results cannot be held off and appear in the cycle after each commit
module sstf_disk_request_scheduler_core #(
  parameter int MAX_REQUESTS = sstf_pkg::MAX_REQUESTS_DEF,
  parameter int CYL_BITS     = sstf_pkg::CYL_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  sstf_pkg::req_t                   req,
  input  logic                             cfg_we,
  input  logic [sstf_pkg::CYL_FIELD_W-1:0] cfg_wdata,
  output logic                             done,
  output sstf_pkg::res_t                   res
);

  localparam int IDX_W = $clog2(MAX_REQUESTS);
  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

  sstf_pkg::cmd_t   cmd;
  logic [IDX_W-1:0] scan_addr;
  logic [CNT_W-1:0] count;

  sstf_ctrl #(
    .MAX_REQUESTS(MAX_REQUESTS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .last_request(req.last_request),
    .count       (count),
    .busy        (busy),
    .cmd         (cmd),
    .scan_addr   (scan_addr)
  );

  sstf_datapath #(
    .MAX_REQUESTS(MAX_REQUESTS),
    .CYL_BITS    (CYL_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .scan_addr(scan_addr),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .count    (count),
    .done     (done),
    .res      (res)
  );

endmodule

// ===== rtl/sstf_checker.sv =====
module sstf_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input sstf_pkg::req_t req,
  input logic           done,
  input sstf_pkg::res_t res
);

  // last request of a batch starts scheduling
  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.last_request) |=> busy)
    else $error("busy not raised after last request");

  // a plain request is absorbed without raising busy
  a_plain_request: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !req.last_request) |=> !busy)
    else $error("busy raised by a request that is not the last");

  // every selection rescans the store, so results never come back to back
  a_result_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("results on consecutive cycles");

  // final result lands with the block idle, others while still busy
  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    (done && res.last_result) |-> !busy)
    else $error("busy after final result");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    (done && !res.last_result) |-> busy)
    else $error("idle before final result");

endmodule

bind sstf_disk_request_scheduler_core sstf_checker u_sstf_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .req  (req),
  .done (done),
  .res  (res)
);
